// ===== rtl/core/sm3he_pkg.sv =====
// Package for the SM3-256 hash engine: payload types, IV, round constants,
// and the permutation helpers. Used by every module under rtl/core.
`timescale 1ns / 1ps
package sm3he_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [31:0] IV0 = 32'h7380166f;
  localparam logic [31:0] IV1 = 32'h4914b2b9;
  localparam logic [31:0] IV2 = 32'h172442d7;
  localparam logic [31:0] IV3 = 32'hda8a0600;
  localparam logic [31:0] IV4 = 32'ha96f30bc;
  localparam logic [31:0] IV5 = 32'h163138aa;
  localparam logic [31:0] IV6 = 32'he38dee4d;
  localparam logic [31:0] IV7 = 32'hb0fb0e4e;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [31:0] TLow  = 32'h79cc4519;
  localparam logic [31:0] THigh = 32'h7a879d8a;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== rtl/core/sm3he_queue.sv =====
// Short FIFO of input beats between the front and the compression back end.
// Depends on sm3he_pkg.
`timescale 1ns / 1ps
module sm3he_queue import sm3he_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t push_data,
  output logic     full,
  input  logic     pop,
  output in_item_t pop_data,
  output logic     nonempty
);
  in_item_t         slots [QDepth];
  logic [QAw-1:0]   wr_ptr;
  logic [QAw-1:0]   rd_ptr;
  logic [QAw:0]     count;

  assign full     = (count == (QAw+1)'(QDepth));
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  // Pointer and occupancy update
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end
endmodule

// ===== rtl/core/sm3he_core.sv =====
// Back end: block assembly, padding, message expansion and 64 rounds, digest
// output register. Depends on sm3he_pkg.
`timescale 1ns / 1ps
module sm3he_core import sm3he_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  in_item_t  item,
  output logic      item_take,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]   state;
  logic [5:0]   fill;
  logic [63:0]  bit_length;
  logic [31:0]  cv [8];
  logic [31:0]  rv [8];
  logic [31:0]  w  [16];
  logic [511:0] blk;
  logic [5:0]   rnd;
  logic         finishing;  // message ends with the blocks still to come
  logic         pad_done;   // 0x80 already placed
  logic         closing;    // length words are in the block in flight
  logic [2:0]   oidx;

  // Round datapath on a sliding 16-word window of W
  logic [31:0] t_j, a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  always_comb begin
    t_j   = rotl((rnd < 6'd16) ? TLow : THigh, rnd[4:0]);
    a12   = rotl(rv[0], 5'd12);
    ss1   = rotl(a12 + rv[4] + t_j, 5'd7);
    ss2   = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = rv[0] ^ rv[1] ^ rv[2];
      gg = rv[4] ^ rv[5] ^ rv[6];
    end else begin
      ff = (rv[0] & rv[1]) | (rv[0] & rv[2]) | (rv[1] & rv[2]);
      gg = (rv[4] & rv[5]) | (~rv[4] & rv[6]);
    end
    tt1   = ff + rv[3] + ss2 + (w[0] ^ w[4]);
    tt2   = gg + rv[7] + ss1 + w[0];
    w_new = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  assign item_take = (state == S_IDLE) && item_valid;
  assign out_valid = (state == S_OUT);
  assign out_data  = '{digest_word: cv[oidx], word_index: oidx,
                       last_word: (oidx == 3'd7)};

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      bit_length <= '0;
      finishing  <= 1'b0;
      pad_done   <= 1'b0;
      closing    <= 1'b0;
      oidx       <= '0;
      cv <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            // fill wraps to zero when the block fills
            if (item.byte_valid) begin
              blk[511 - 8*fill -: 8] <= item.msg_byte;
              fill       <= fill + 1'b1;
              bit_length <= bit_length + 64'd8;
            end
            finishing <= item.last;
            pad_done  <= 1'b0;
            closing   <= 1'b0;
            rnd <= '0;
            for (int i = 0; i < 8; i++) rv[i] <= cv[i];
            if (item.byte_valid && fill == 6'd63) begin
              state <= S_RND;
              for (int i = 0; i < 15; i++) w[i] <= blk[511 - 32*i -: 32];
              w[15] <= {blk[31:8], item.msg_byte};
            end else if (item.last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // One byte per cycle: 0x80 then zeros up to the length field, or to the block end when past it
          blk[511 - 8*fill -: 8] <= pad_done ? 8'h00 : PadByte;
          pad_done <= 1'b1;
          fill     <= fill + 1'b1;
          if (fill == 6'd55) state <= S_LEN;
          else if (fill == 6'd63) begin
            state <= S_RND;
            rnd   <= '0;
            for (int i = 0; i < 15; i++) w[i] <= blk[511 - 32*i -: 32];
            w[15] <= {blk[31:8], pad_done ? 8'h00 : PadByte};
            for (int i = 0; i < 8; i++) rv[i] <= cv[i];
          end
        end
        S_LEN: begin
          for (int i = 0; i < 14; i++) w[i] <= blk[511 - 32*i -: 32];
          w[14] <= bit_length[63:32];
          w[15] <= bit_length[31:0];
          for (int i = 0; i < 8; i++) rv[i] <= cv[i];
          rnd      <= '0;
          fill     <= '0;
          pad_done <= 1'b0;
          closing  <= 1'b1;
          state    <= S_RND;
        end
        S_RND: begin
          rv[3] <= rv[2];
          rv[2] <= rotl(rv[1], 5'd9);
          rv[1] <= rv[0];
          rv[0] <= tt1;
          rv[7] <= rv[6];
          rv[6] <= rotl(rv[5], 5'd19);
          rv[5] <= rv[4];
          rv[4] <= perm0(tt2);
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd   <= rnd + 1'b1;
          if (rnd == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) cv[i] <= cv[i] ^ rv[i];
          oidx <= '0;
          // fill is zero here; a finishing message without its length block pads on
          if (!finishing)    state <= S_IDLE;
          else if (closing)  state <= S_OUT;
          else               state <= S_PAD;
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx <= oidx + 1'b1;
            if (oidx == 3'd7) begin
              state      <= S_IDLE;
              cv <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
              bit_length <= '0;
              fill       <= '0;
              finishing  <= 1'b0;
              pad_done   <= 1'b0;
              closing    <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/sm3_hash_engine_unit.sv =====
// Top level of the SM3-256 hash engine: input queue (front) and
// compression back end. Depends on sm3he_pkg, sm3he_queue, sm3he_core.
//
//  channel | payload     | handshake
//  in      | in_item_t   | in_valid / in_stall
//  out     | out_item_t  | out_valid / out_stall
//
// A byte beat is queued, then taken by the back end when it is idle.
// A full block goes through the take, 64 rounds and the fold.
// Last pads one byte per cycle through byte 55 (to the block end first if past
// it), loads the length, then one or two compressions, then eight digest beats.
// Reset clears the queue and restores the IV.
// An output stall holds the current digest beat; the queue takes input until full.
`timescale 1ns / 1ps
module sm3_hash_engine_unit import sm3he_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  logic     q_full, q_nonempty, q_pop;
  in_item_t q_data;

  assign in_stall = q_full;

  sm3he_queue u_queue (
    .clk(clk), .rst(rst),
    .push(in_valid && !q_full), .push_data(in_data), .full(q_full),
    .pop(q_pop), .pop_data(q_data), .nonempty(q_nonempty)
  );

  sm3he_core u_core (
    .clk(clk), .rst(rst),
    .item_valid(q_nonempty), .item(q_data), .item_take(q_pop),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );
endmodule

// ===== rtl/core/sm3he_checker.sv =====
// Port-level checker for sm3_hash_engine_unit and its bind.
// Depends on sm3he_pkg.
`timescale 1ns / 1ps
module sm3he_checker import sm3he_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);
  // Digest beats come in order
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.word_index != 3'd7 |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest index skipped");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word mismatch");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled digest changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Queue is empty right after reset
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");
endmodule

bind sm3_hash_engine_unit sm3he_checker u_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== test/tb_sm3_hash_engine_unit.sv =====
// Testbench for sm3_hash_engine_unit: directed and random byte streams, checked
// beat by beat against a behavioral SM3-256 model kept inside this file.
// Depends on sm3he_pkg (payload types) and the RTL under rtl/core.
`timescale 1ns / 1ps
module tb_sm3_hash_engine_unit;
  import sm3he_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sm3_hash_engine_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  localparam logic [31:0] EmptyHash0 = 32'h1ab21d83;

  // Hash state kept by the checker
  logic [31:0] hv [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] nbits;

  out_item_t   digest_q [$];
  int          errors;
  int          beats_in;
  int          beats_out;
  int          digests;
  logic        hold_off;
  bit          hold_used;
  bit          tx_done;
  logic [31:0] last_w0;

  // Directed rows; check_w0 pins digest word 0 of a message ending on that row
  typedef struct {
    logic [7:0]  b;
    logic        v;
    logic        l;
    bit          check_w0;
    logic [31:0] w0;
  } row_t;
  row_t dir_rows [$];

  function automatic logic [31:0] rl(input logic [31:0] x, input int n);
    rl = (n % 32 == 0) ? x : ((x << (n % 32)) | (x >> (32 - n % 32)));
  endfunction

  function automatic logic [31:0] p0f(input logic [31:0] x);
    p0f = x ^ rl(x, 9) ^ rl(x, 17);
  endfunction

  function automatic logic [31:0] p1f(input logic [31:0] x);
    p1f = x ^ rl(x, 15) ^ rl(x, 23);
  endfunction

  task automatic restart_hash();
    hv[0] = IV0; hv[1] = IV1; hv[2] = IV2; hv[3] = IV3;
    hv[4] = IV4; hv[5] = IV5; hv[6] = IV6; hv[7] = IV7;
    fill = 0;
    nbits = '0;
  endtask

  task automatic fold_block();
    logic [31:0] w [68];
    logic [31:0] v [8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = p1f(w[j-16] ^ w[j-9] ^ rl(w[j-3], 15)) ^ rl(w[j-13], 7) ^ w[j-6];
    for (int k = 0; k < 8; k++) v[k] = hv[k];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? TLow : THigh;
      a12 = rl(v[0], 12);
      ss1 = rl(a12 + v[4] + rl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2]; v[2] = rl(v[1], 9); v[1] = v[0]; v[0] = tt1;
      v[7] = v[6]; v[6] = rl(v[5], 19); v[5] = v[4]; v[4] = p0f(tt2);
    end
    for (int k = 0; k < 8; k++) hv[k] ^= v[k];
  endtask

  // Absorb one accepted beat; on last, pad and queue the eight digest words
  task automatic absorb_beat(input in_item_t it);
    out_item_t o;
    if (it.byte_valid) begin
      blk[fill] = it.msg_byte;
      fill++;
      nbits += 64'd8;
      if (fill == 64) begin
        fold_block();
        fill = 0;
      end
    end
    if (it.last) begin
      blk[fill] = PadByte;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin blk[fill] = 8'h00; fill++; end
        fold_block();
        fill = 0;
      end
      while (fill < 56) begin blk[fill] = 8'h00; fill++; end
      for (int i = 0; i < 8; i++) blk[56+i] = nbits[63-8*i -: 8];
      fold_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hv[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        digest_q.push_back(o);
      end
      restart_hash();
    end
  endtask

  // Input monitor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      absorb_beat(in_data);
      beats_in++;
    end
  end

  // Output checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (out_data.word_index == 3'd0) last_w0 = out_data.digest_word;
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest beat exp none got %h", $time, out_data);
      end else begin
        e = digest_q.pop_front();
        if (e.last_word) digests++;
        if (out_data.digest_word !== e.digest_word || out_data.word_index !== e.word_index
            || out_data.last_word !== e.last_word) begin
          errors++;
          $display("%0t: digest mismatch exp %h/%0d/%b got %h/%0d/%b", $time,
                   e.digest_word, e.word_index, e.last_word, out_data.digest_word,
                   out_data.word_index, out_data.last_word);
        end
      end
    end
  end

  // Receiver stalls; hold_off forces a long stretch
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      int gap;
      gap = (tx_done || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Offer one beat with a random idle gap ahead of it unless calm
  task automatic send_beat(input logic [7:0] b, input logic v, input logic l, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{msg_byte: b, byte_valid: v, last: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic v, input logic l,
                         input bit c, input logic [31:0] w);
    row_t r;
    r.b = b; r.v = v; r.l = l; r.check_w0 = c; r.w0 = w;
    dir_rows.push_back(r);
  endtask

  initial begin
    int   len, sent;
    bit   calm;
    errors = 0; beats_in = 0; beats_out = 0; digests = 0;
    hold_off = 1'b0; hold_used = 1'b0; tx_done = 1'b0;
    last_w0 = '0;
    restart_hash();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, "abc", byte and last together, extremes,
    // ignored byte on an empty final beat
    add_row(8'h00, 1'b0, 1'b1, 1'b1, EmptyHash0);
    add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h63, 1'b1, 1'b1, 1'b1, 32'h66c7f0f4);
    add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'haa, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'h55, 1'b1, 1'b1, 1'b0, '0);
    for (int r = 0; r < dir_rows.size(); r++) begin
      send_beat(dir_rows[r].b, dir_rows[r].v, dir_rows[r].l, 1'b0);
      if (dir_rows[r].check_w0) begin
        wait_digests();
        if (last_w0 !== dir_rows[r].w0) begin
          errors++;
          $display("%0t: digest word 0 exp %h got %h", $time, dir_rows[r].w0, last_w0);
        end
      end
    end
    wait_digests();

    // Fixed check values sit in the row table; compare word 0 of the known hashes
    // by rerunning them through the checker is redundant, so check the empty hash
    begin
      restart_hash();
      blk[0] = PadByte;
      for (int k = 1; k < 64; k++) blk[k] = 8'h00;
      fold_block();
      if (hv[0] !== EmptyHash0) begin
        errors++;
        $display("%0t: empty hash exp %h got %h", $time, EmptyHash0, hv[0]);
      end
      restart_hash();
    end

    // Random messages; short lengths and lengths around the padding and block boundaries
    sent = dir_rows.size();
    while (sent < 310) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(54, 66);
        2: len = $urandom_range(118, 130);
        default: len = $urandom_range(4, 40);
      endcase
      if (sent + len + 1 > 310) len = 310 - sent - 1;
      calm = ($urandom_range(0, 4) == 0);
      if (sent > 150 && !hold_used) begin
        hold_off  = 1'b1;
        hold_used = 1'b1;
      end
      for (int k = 0; k < len; k++) begin
        // occasional noise beat carrying no byte
        if ($urandom_range(0, 15) == 0)
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, calm);
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, calm);
        sent++;
      end
      if ($urandom_range(0, 1) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1, calm);
      else
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, calm);
      sent++;
      if ($urandom_range(0, 5) == 0) wait_digests();
    end
    in_valid <= 1'b0;
    tx_done = 1'b1;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Run covered %0d input beats and %0d digest beats (%0d digests).",
             beats_in, beats_out, digests);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
